// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ----- rtl/cbck_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cbck_pkg;

    localparam int MAX_DIM_DEF     = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CFG_W           = 13;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int ADDR_W          = 24;
    localparam int COLOR_W         = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DST_WIDTH  = 3'd0,
        REG_DST_HEIGHT = 3'd1,
        REG_SRC_WIDTH  = 3'd2,
        REG_DST_X      = 3'd3,
        REG_DST_Y      = 3'd4,
        REG_KEY_COLOR  = 3'd5,
        REG_KEY_ENABLE = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic               first_of_image;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  dst_address;
        logic [COLOR_W-1:0] write_color;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0]   dst_width;
        logic [CFG_W-1:0]   dst_height;
        logic [CFG_W-1:0]   src_width;
        logic [CFG_W-1:0]   dst_x;
        logic [CFG_W-1:0]   dst_y;
        logic [COLOR_W-1:0] key_color;
        logic               key_enable;
    } t_cfg;

    // One surviving pixel, already clipped: in-bounds destination position.
    typedef struct packed {
        logic [CFG_W-1:0]   py;
        logic [CFG_W-1:0]   px;
        logic [COLOR_W-1:0] color;
    } t_job;

endpackage

`default_nettype wire

// ----- rtl/clipped_blit_color_key.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Color-keyed clipped blitter. Source pixels enter in raster order, one per clock,
// on the valid/stall request channel; column and row are counted here and first_of_image
// restarts them. Pixels outside the destination, or equal to the key color while keying is
// on, are dropped; each survivor leaves as one request with address y*dst_width+x (low 24
// bits) and its color. The front stage counts and clips in the accept cycle and pushes into
// a QUEUE_DEPTH-entry queue; the back stage does the address multiply and loads the output
// register. Sustained rate is one pixel per clock while the output is not stalled; a
// surviving pixel is written into the queue at the edge that accepts it, then passes from
// the queue head into the output register. Input stall rises only when the queue is full.
// Write configuration only while the block is idle.
module clipped_blit_color_key #(
    parameter int MAX_DIM     = cbck_pkg::MAX_DIM_DEF,
    parameter int QUEUE_DEPTH = cbck_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cbck_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cbck_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_valid,
    input  wire cbck_pkg::t_in_item              i_in,
    output logic                                 o_stall,
    output logic                                 o_valid,
    output cbck_pkg::t_out_item                  o_out,
    input  wire logic                            i_stall
);
    import cbck_pkg::*;

    t_cfg r_cfg;
    t_job front_job, head_job;
    logic push, pop, q_empty, q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dst_width  <= CFG_W'(320);
            r_cfg.dst_height <= CFG_W'(240);
            r_cfg.src_width  <= CFG_W'(1);
            r_cfg.dst_x      <= '0;
            r_cfg.dst_y      <= '0;
            r_cfg.key_color  <= '0;
            r_cfg.key_enable <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_DST_WIDTH:  r_cfg.dst_width  <= i_cfg_data[CFG_W-1:0];
                REG_DST_HEIGHT: r_cfg.dst_height <= i_cfg_data[CFG_W-1:0];
                REG_SRC_WIDTH:  r_cfg.src_width  <= i_cfg_data[CFG_W-1:0];
                REG_DST_X:      r_cfg.dst_x      <= i_cfg_data[CFG_W-1:0];
                REG_DST_Y:      r_cfg.dst_y      <= i_cfg_data[CFG_W-1:0];
                REG_KEY_COLOR:  r_cfg.key_color  <= i_cfg_data[COLOR_W-1:0];
                REG_KEY_ENABLE: r_cfg.key_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    cbck_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_stall (o_stall),
        .o_push  (push),
        .o_job   (front_job)
    );

    cbck_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    cbck_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dst_width (r_cfg.dst_width),
        .i_job       (head_job),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ----- rtl/cbck_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cbck_front #(
    parameter int MAX_DIM = cbck_pkg::MAX_DIM_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cbck_pkg::t_cfg    i_cfg,
    input  wire logic              i_valid,
    input  wire cbck_pkg::t_in_item i_in,
    input  wire logic              i_full,
    output logic                   o_stall,
    output logic                   o_push,
    output cbck_pkg::t_job         o_job
);
    import cbck_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int PW = EW + 1;

    logic [CW-1:0]        r_col, r_row, n_col, n_row;
    logic [CW-1:0]        col_use, row_use;
    logic [EW-1:0]        src_w_ext, eff_w, col_inc;
    logic [CW:0]          row_inc;
    logic signed [PW-1:0] dx_ext, dy_ext, cx_ext, cy_ext, px, py;
    logic                 accept, x_in, y_in, key_hit;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    assign col_use = i_in.first_of_image ? '0 : r_col;
    assign row_use = i_in.first_of_image ? '0 : r_row;

    // Zero or oversize source width acts as the full dimension.
    assign src_w_ext = EW'(i_cfg.src_width);
    assign eff_w = (src_w_ext == '0 || src_w_ext > EW'(MAX_DIM)) ? EW'(MAX_DIM) : src_w_ext;

    assign col_inc = EW'(col_use) + EW'(1);
    assign row_inc = {1'b0, row_use} + (CW+1)'(1);

    always_comb begin
        n_col = CW'(col_inc);
        n_row = row_use;
        if (col_inc >= eff_w) begin
            n_col = '0;
            n_row = (row_inc >= (CW+1)'(MAX_DIM)) ? '0 : CW'(row_inc);
        end
    end

    assign dx_ext = {{(PW-CFG_W){i_cfg.dst_x[CFG_W-1]}}, i_cfg.dst_x};
    assign dy_ext = {{(PW-CFG_W){i_cfg.dst_y[CFG_W-1]}}, i_cfg.dst_y};
    assign cx_ext = $signed(PW'(col_use));
    assign cy_ext = $signed(PW'(row_use));
    assign px = dx_ext + cx_ext;
    assign py = dy_ext + cy_ext;

    assign x_in    = !px[PW-1] && (px[PW-2:0] < (PW-1)'(i_cfg.dst_width));
    assign y_in    = !py[PW-1] && (py[PW-2:0] < (PW-1)'(i_cfg.dst_height));
    assign key_hit = i_cfg.key_enable && (i_in.pixel_color == i_cfg.key_color);

    assign o_push      = accept && x_in && y_in && !key_hit;
    assign o_job.px    = px[CFG_W-1:0];
    assign o_job.py    = py[CFG_W-1:0];
    assign o_job.color = i_in.pixel_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    `ASSERT_CLK(a_row_range, i_clk, i_rst_n, (CW+1)'(r_row) < (CW+1)'(MAX_DIM), "row out of range")

endmodule

`default_nettype wire

// ----- rtl/cbck_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cbck_fifo #(
    parameter int DEPTH = cbck_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cbck_pkg::t_job i_job,
    input  wire logic           i_pop,
    output cbck_pkg::t_job      o_head,
    output logic                o_empty,
    output logic                o_full
);
    import cbck_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [NW-1:0] r_count;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == NW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + NW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    `ASSERT_NEVER(a_overflow, i_clk, i_rst_n, (i_push && o_full && !i_pop), "push into full queue")
    `ASSERT_NEVER(a_underflow, i_clk, i_rst_n, (i_pop && o_empty), "pop from empty queue")

endmodule

`default_nettype wire

// ----- rtl/cbck_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cbck_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [cbck_pkg::CFG_W-1:0] i_dst_width,
    input  wire cbck_pkg::t_job             i_job,
    input  wire logic                       i_empty,
    output logic                            o_pop,
    input  wire logic                       i_stall,
    output logic                            o_valid,
    output cbck_pkg::t_out_item             o_out
);
    import cbck_pkg::*;

    logic [2*CFG_W-1:0] prod, addr_full;
    logic               r_valid;
    t_out_item          r_out;

    assign prod      = (2*CFG_W)'(i_job.py) * (2*CFG_W)'(i_dst_width);
    assign addr_full = prod + (2*CFG_W)'(i_job.px);

    // Load the output register whenever the queue holds an entry and the register is empty or being taken.
    assign o_pop = !i_empty && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.dst_address <= addr_full[ADDR_W-1:0];
            r_out.write_color <= i_job.color;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, (r_valid && i_stall && o_pop), "held result overwritten")

endmodule

`default_nettype wire
